>>> rtl/msb_first_bitstream_buffer_defines.svh
// Assertion macros for the MSB-first bitstream buffer.
`ifndef MSB_FIRST_BITSTREAM_BUFFER_DEFINES_SVH
`define MSB_FIRST_BITSTREAM_BUFFER_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define MFBB_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define MFBB_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/mfbb_pkg.sv
// Shared types and constants for the MSB-first bitstream buffer.
package mfbb_pkg;

  localparam int STORE_BYTES = 4096;
  localparam int ADDR_W      = 12;   // byte store address
  localparam int POS_W       = 13;   // cursor / length, can hold STORE_BYTES
  localparam int MAX_BITS    = 32;
  localparam int CNT_W       = 6;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [1:0]       status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_READ_PAST = 2'd1;
  localparam status_t ST_PROTECTED = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  localparam pos_t STORE_END  = pos_t'(STORE_BYTES);
  localparam cnt_t MAX_COUNT  = cnt_t'(MAX_BITS);

  // register index, taken from paddr[2]
  localparam logic REG_WRITE_PROTECT = 1'b0;

endpackage

>>> rtl/mfbb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module mfbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/msb_first_bitstream_buffer.sv
// MSB-first bit packer/unpacker over a 4096-byte store with read and write cursors.
// Items are handled one at a time; the store is walked one byte per cycle (a 32-bit access
// spans at most five bytes), and the result then waits in the hold state until the output
// register is free; an item that touches no byte goes straight to the hold state.
// Reset (rst_n low, synchronous) homes both cursors, clears used length and write_protect;
// bytes at or above the used length are never read and a fresh byte starts from zero.
`include "msb_first_bitstream_buffer_defines.svh"

module msb_first_bitstream_buffer (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [5:0] bit_count, [37:6] write_value, [39:38] zero
  input  logic        in_tuser,   // [0] mode
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] read_value
  output logic [1:0]  out_tuser,  // [1:0] status
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mfbb_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WR   = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0]  state_r, state_nxt;
  pos_t        rbyte_r, rbyte_nxt;
  logic [2:0]  rbit_r, rbit_nxt;
  pos_t        wbyte_r, wbyte_nxt;
  logic [2:0]  wbit_r, wbit_nxt;
  pos_t        used_r, used_nxt;
  logic        wp_r;
  logic [7:0]  wcur_r, wcur_nxt;     // current contents of the byte under the write cursor
  cnt_t        rem_r, rem_nxt;
  logic [31:0] sh_r, sh_nxt;         // remaining write bits, left aligned
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] res_val_r, res_val_nxt;
  status_t     res_st_r, res_st_nxt;
  logic        out_tvalid_r, out_tvalid_nxt;
  logic [31:0] out_tdata_r;
  status_t     out_tuser_r;

  logic        in_acc;
  logic        out_load;
  logic        cfg_wr;
  cnt_t        n_sat;
  logic [63:0] wv_ext;
  logic [16:0] new_bits;
  logic [13:0] new_len;
  logic [2:0]  cur_bit;
  logic [3:0]  avail;
  logic [3:0]  take;
  logic [7:0]  rd_bits;
  logic [7:0]  wr_bits;
  logic [7:0]  wr_byte;
  cnt_t        rem_dec;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;

  mfbb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_load   = (state_r == S_HOLD) && (!out_tvalid_r || out_tready);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_WRITE_PROTECT);
  assign cfg_prdata = (cfg_paddr[2] == REG_WRITE_PROTECT) ? {31'b0, wp_r} : 32'b0;

  assign n_sat    = (in_tdata[5:0] > MAX_COUNT) ? MAX_COUNT : in_tdata[5:0];
  assign wv_ext   = {32'b0, in_tdata[37:6]} << (MAX_COUNT - n_sat);
  assign new_bits = {1'b0, wbyte_r, 3'b000} + 17'(3'd7 - wbit_r) + 17'(n_sat);
  assign new_len  = 14'((new_bits + 17'd7) >> 3);

  // one byte step, shared by read and write
  assign cur_bit = (state_r == S_WR) ? wbit_r : rbit_r;
  assign avail   = {1'b0, cur_bit} + 4'd1;
  assign take    = (rem_r < {2'b0, avail}) ? rem_r[3:0] : avail;
  assign rem_dec = rem_r - {2'b0, take};
  assign rd_bits = (mem_rdata >> (avail - take)) & (8'hFF >> (4'd8 - take));
  assign wr_bits = sh_r[31:24] >> (4'd8 - take);
  assign wr_byte = wcur_r | 8'(wr_bits << (avail - take));

  assign mem_we    = (state_r == S_WR);
  assign mem_waddr = wbyte_r[ADDR_W-1:0];
  assign mem_wdata = wr_byte;
  assign mem_raddr = (state_r == S_RD) ? rbyte_nxt[ADDR_W-1:0] : rbyte_r[ADDR_W-1:0];

  always_comb begin
    state_nxt   = state_r;
    rbyte_nxt   = rbyte_r;
    rbit_nxt    = rbit_r;
    wbyte_nxt   = wbyte_r;
    wbit_nxt    = wbit_r;
    used_nxt    = used_r;
    wcur_nxt    = wcur_r;
    rem_nxt     = rem_r;
    sh_nxt      = sh_r;
    acc_nxt     = acc_r;
    res_val_nxt = res_val_r;
    res_st_nxt  = res_st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_val_nxt = 32'b0;
          res_st_nxt  = ST_OK;
          rem_nxt     = n_sat;
          acc_nxt     = 32'b0;
          sh_nxt      = wv_ext[31:0];
          state_nxt   = S_HOLD;
          if (!in_tuser) begin
            if (rbyte_r >= used_r) begin
              res_st_nxt = ST_READ_PAST;
            end else if (n_sat != '0) begin
              state_nxt = S_RD;   // first byte read issued now
            end
          end else if (wp_r) begin
            res_st_nxt = ST_PROTECTED;
          end else if ((new_len > 14'(STORE_BYTES)) || (wbyte_r >= STORE_END)) begin
            res_st_nxt = ST_FULL;
          end else begin
            if (new_len[POS_W-1:0] > used_r) begin
              used_nxt = new_len[POS_W-1:0];
            end
            if (n_sat != '0) begin
              state_nxt = S_WR;
            end
          end
        end
      end
      S_RD: begin
        acc_nxt = (acc_r << take) | {24'b0, rd_bits};
        rem_nxt = rem_dec;
        if (take == avail) begin
          rbyte_nxt = rbyte_r + pos_t'(1);
          rbit_nxt  = 3'd7;
        end else begin
          rbit_nxt  = rbit_r - take[2:0];
        end
        if (rem_dec == '0) begin
          res_val_nxt = acc_nxt;
          res_st_nxt  = ST_OK;
          state_nxt   = S_HOLD;
        end else if (rbyte_nxt >= used_r) begin
          // ran past the end: cursor advance stays
          res_val_nxt = 32'b0;
          res_st_nxt  = ST_READ_PAST;
          state_nxt   = S_HOLD;
        end
      end
      S_WR: begin
        sh_nxt  = sh_r << take;
        rem_nxt = rem_dec;
        if (take == avail) begin
          wbyte_nxt = wbyte_r + pos_t'(1);
          wbit_nxt  = 3'd7;
          wcur_nxt  = 8'b0;
        end else begin
          wbit_nxt  = wbit_r - take[2:0];
          wcur_nxt  = wr_byte;
        end
        if (rem_dec == '0) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rbyte_r      <= '0;
      rbit_r       <= 3'd7;
      wbyte_r      <= '0;
      wbit_r       <= 3'd7;
      used_r       <= '0;
      wcur_r       <= 8'b0;
      wp_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rbyte_r      <= rbyte_nxt;
      rbit_r       <= rbit_nxt;
      wbyte_r      <= wbyte_nxt;
      wbit_r       <= wbit_nxt;
      used_r       <= used_nxt;
      wcur_r       <= wcur_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr) begin
        wp_r <= cfg_pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    sh_r      <= sh_nxt;
    acc_r     <= acc_nxt;
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
    if (out_load) begin
      out_tdata_r <= res_val_r;
      out_tuser_r <= res_st_r;
    end
  end

  `MFBB_ASSERT_ALWAYS(a_used_in_range, used_r <= STORE_END, "used length beyond store")
  `MFBB_ASSERT_ALWAYS(a_rd_within_used, rbyte_r <= used_r, "read cursor past used length")
  `MFBB_ASSERT_IMPLY(a_partial_covered, wbit_r != 3'd7, wbyte_r < used_r, "partial byte not in used")
  `MFBB_ASSERT_IMPLY(a_we_only_in_write, mem_we, state_r == S_WR && rem_r != '0, "stray store write")

endmodule

>>> verif/tb_msb_first_bitstream_buffer.sv
// Testbench for the MSB-first bitstream buffer: directed table plus random bit packing and unpacking.
`timescale 1ns / 1ps

module tb_msb_first_bitstream_buffer;
  import mfbb_pkg::*;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;
  localparam int   SETTLE_CYCLES = 8;   // worst item latency plus margin

  typedef enum logic {ROW_ITEM, ROW_PROTECT} row_kind_e;

  typedef struct packed {
    logic [31:0] read_value;
    status_t     status;
  } outcome_t;

  typedef struct {
    row_kind_e   kind;
    logic        mode;
    cnt_t        count;
    logic [31:0] value;
    bit          typed;
    outcome_t    want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [5:0] bit_count, [37:6] write_value, [39:38] zero
  logic        in_tuser;   // [0] mode
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] read_value
  logic [1:0]  out_tuser;  // [1:0] status
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  msb_first_bitstream_buffer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // shadow of the store and both cursors
  bit [7:0]   store_img [STORE_BYTES];
  pos_t       rd_pos   = '0;
  logic [2:0] rd_bit   = 3'd7;
  pos_t       wr_pos   = '0;
  logic [2:0] wr_bit   = 3'd7;
  pos_t       fill_len = '0;
  logic       protect_on = 1'b0;

  outcome_t   outcome_q [$];
  stim_row_t  dir_rows [$];
  int         mismatches = 0;
  int         full_hits = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic bit readable(pos_t p);
    return p < fill_len && p < STORE_END;
  endfunction

  function automatic status_t unpack_bits(int unsigned n, output logic [31:0] bits_out);
    logic [31:0] acc;
    logic [7:0]  cur;
    acc = '0;
    bits_out = '0;
    if (!readable(rd_pos)) return ST_READ_PAST;
    cur = store_img[rd_pos[ADDR_W-1:0]];
    while (n > 0) begin
      acc = {acc[30:0], cur[rd_bit]};
      if (rd_bit == 3'd0) begin
        rd_bit = 3'd7;
        rd_pos = rd_pos + 1'b1;
        // cursor advance is kept when the next byte is out of range
        if (n > 1) begin
          if (!readable(rd_pos)) return ST_READ_PAST;
          cur = store_img[rd_pos[ADDR_W-1:0]];
        end
      end else begin
        rd_bit = rd_bit - 1'b1;
      end
      n--;
    end
    bits_out = acc;
    return ST_OK;
  endfunction

  function automatic status_t pack_bits(int unsigned n, logic [31:0] val);
    int unsigned end_bits;
    int unsigned end_len;
    bit [7:0]    cur;
    bit          open_byte;
    if (protect_on) return ST_PROTECTED;
    end_bits = int'(wr_pos) * 8 + (7 - int'(wr_bit)) + n;
    end_len  = (end_bits + 7) / 8;
    if (end_len > STORE_BYTES || wr_pos >= STORE_END) return ST_FULL;
    if (end_len > fill_len) fill_len = pos_t'(end_len);
    // first byte is merged, later bytes start from zero
    cur = store_img[wr_pos[ADDR_W-1:0]];
    open_byte = 1'b0;
    while (n > 0) begin
      cur[wr_bit] = cur[wr_bit] | val[n-1];
      open_byte = 1'b1;
      if (wr_bit == 3'd0) begin
        store_img[wr_pos[ADDR_W-1:0]] = cur;
        cur = '0;
        wr_pos = wr_pos + 1'b1;
        wr_bit = 3'd7;
        open_byte = 1'b0;
      end else begin
        wr_bit = wr_bit - 1'b1;
      end
      n--;
    end
    if (open_byte && wr_pos < STORE_END) store_img[wr_pos[ADDR_W-1:0]] = cur;
    return ST_OK;
  endfunction

  function automatic outcome_t predict_word(logic mode, cnt_t count, logic [31:0] value);
    outcome_t    o;
    int unsigned n;
    logic [31:0] bits;
    n = (count > MAX_COUNT) ? MAX_BITS : count;
    bits = '0;
    if (mode == MODE_WRITE) o.status = pack_bits(n, value);
    else o.status = unpack_bits(n, bits);
    o.read_value = bits;
    if (o.status == ST_FULL) full_hits++;
    return o;
  endfunction

  task automatic check_result(logic [31:0] got_value, status_t got_status);
    outcome_t want;
    if (outcome_q.size() == 0) begin
      report_mismatch($sformatf("unexpected word value=%h status=%0d", got_value, got_status));
      return;
    end
    want = outcome_q.pop_front();
    if (got_value !== want.read_value)
      report_mismatch($sformatf("read_value %h, want %h", got_value, want.read_value));
    if (got_status !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", got_status, want.status));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result(out_tdata, out_tuser);
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_item(logic mode, cnt_t count, logic [31:0] value, bit typed,
                           outcome_t typed_want);
    outcome_t predicted;
    // sender idles cycle by cycle at the phase's rate
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, value, count};
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    predicted = predict_word(mode, count, value);
    outcome_q.push_back(typed ? typed_want : predicted);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_protect(logic enable);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_WRITE_PROTECT, 2'b00};
    cfg_pwdata  <= {31'd0, enable};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    protect_on = enable;
    // read back in a second transfer
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {31'd0, enable})
      report_mismatch($sformatf("write_protect reads %h, want %0d", cfg_prdata, enable));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic add_row(row_kind_e kind, logic mode, cnt_t count, logic [31:0] value,
                         bit typed, logic [31:0] want_value, status_t want_status);
    stim_row_t r;
    r.kind  = kind;
    r.mode  = mode;
    r.count = count;
    r.value = value;
    r.typed = typed;
    r.want  = '{read_value: want_value, status: want_status};
    dir_rows.push_back(r);
  endtask

  task automatic run_phase(int items, int idle_pct, int stall_pct, int write_pct,
                           logic protect, bit fill_store);
    logic mode;
    cnt_t count;
    drain_results();
    set_protect(protect);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; fill_store ? (full_hits < 30 && i < 3000) : (i < items); i++) begin
      mode = ($urandom_range(99) < write_pct) ? MODE_WRITE : MODE_READ;
      // filling the store leans on long writes
      if (fill_store && mode == MODE_WRITE && $urandom_range(99) < 90)
        count = cnt_t'($urandom_range(32, 63));
      else
        count = cnt_t'($urandom_range(0, 63));
      send_item(mode, count, $urandom, 1'b0, '0);
      if (i == items / 2 && idle_pct > 50) drain_results();
    end
  endtask

  initial begin
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    out_tready  <= 1'b1;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    rst_n       <= 1'b0;

    add_row(ROW_ITEM, MODE_READ,  6'd0,  32'h0,         1, 32'h0,  ST_READ_PAST);
    add_row(ROW_ITEM, MODE_READ,  6'd32, 32'hFFFF_FFFF, 1, 32'h0,  ST_READ_PAST);
    add_row(ROW_ITEM, MODE_WRITE, 6'd8,  32'hA5,        1, 32'h0,  ST_OK);
    add_row(ROW_ITEM, MODE_WRITE, 6'd0,  32'hFFFF_FFFF, 1, 32'h0,  ST_OK);
    add_row(ROW_ITEM, MODE_WRITE, 6'd3,  32'h5,         1, 32'h0,  ST_OK);
    add_row(ROW_ITEM, MODE_WRITE, 6'd32, 32'hFFFF_FFFF, 1, 32'h0,  ST_OK);
    add_row(ROW_ITEM, MODE_WRITE, 6'd63, 32'h8000_0001, 1, 32'h0,  ST_OK);
    add_row(ROW_ITEM, MODE_WRITE, 6'd33, 32'h1234_5678, 1, 32'h0,  ST_OK);
    add_row(ROW_ITEM, MODE_READ,  6'd0,  32'h0,         1, 32'h0,  ST_OK);
    add_row(ROW_ITEM, MODE_READ,  6'd8,  32'h0,         1, 32'hA5, ST_OK);
    add_row(ROW_ITEM, MODE_READ,  6'd3,  32'hFFFF_FFFF, 1, 32'h5,  ST_OK);
    add_row(ROW_ITEM, MODE_READ,  6'd5,  32'h0,         0, 32'h0,  ST_OK);
    add_row(ROW_ITEM, MODE_READ,  6'd32, 32'h0,         0, 32'h0,  ST_OK);
    add_row(ROW_ITEM, MODE_READ,  6'd63, 32'h0,         0, 32'h0,  ST_OK);
    add_row(ROW_ITEM, MODE_READ,  6'd32, 32'h0,         0, 32'h0,  ST_OK);
    add_row(ROW_ITEM, MODE_READ,  6'd32, 32'h0,         0, 32'h0,  ST_OK);
    add_row(ROW_ITEM, MODE_READ,  6'd1,  32'h0,         0, 32'h0,  ST_OK);
    add_row(ROW_PROTECT, MODE_READ, 6'd0, 32'h1,        0, 32'h0,  ST_OK);
    add_row(ROW_ITEM, MODE_WRITE, 6'd32, 32'hDEAD_BEEF, 1, 32'h0,  ST_PROTECTED);
    add_row(ROW_ITEM, MODE_WRITE, 6'd0,  32'h0,         1, 32'h0,  ST_PROTECTED);
    add_row(ROW_ITEM, MODE_READ,  6'd0,  32'h0,         0, 32'h0,  ST_OK);
    add_row(ROW_PROTECT, MODE_READ, 6'd0, 32'h0,        0, 32'h0,  ST_OK);
    add_row(ROW_ITEM, MODE_WRITE, 6'd1,  32'h1,         1, 32'h0,  ST_OK);
    add_row(ROW_ITEM, MODE_WRITE, 6'd32, 32'h0,         1, 32'h0,  ST_OK);
    add_row(ROW_ITEM, MODE_READ,  6'd33, 32'h0,         0, 32'h0,  ST_OK);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_PROTECT) begin
        drain_results();
        set_protect(dir_rows[i].value[0]);
      end else begin
        send_item(dir_rows[i].mode, dir_rows[i].count, dir_rows[i].value,
                  dir_rows[i].typed, dir_rows[i].want);
      end
    end

    run_phase(50, 0,  0,  55, 1'b0, 1'b0);
    // protected and read-heavy: reads catch up with the used length
    run_phase(50, 67, 0,  30, 1'b1, 1'b0);
    run_phase(50, 0,  67, 50, 1'b0, 1'b0);
    // write until the store is full and writes bounce
    run_phase(0,  22, 22, 97, 1'b0, 1'b1);
    run_phase(30, 22, 22, 60, 1'b1, 1'b0);

    drain_results();
    if (mismatches == 0) begin
      $display("tb_msb_first_bitstream_buffer: PASS");
    end else begin
      $display("tb_msb_first_bitstream_buffer: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_msb_first_bitstream_buffer: FAIL");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/mfbb_pkg.sv
rtl/mfbb_ram.sv
rtl/msb_first_bitstream_buffer.sv
verif/tb_msb_first_bitstream_buffer.sv
